@@ hdl/drme_pkg.sv @@
// ----------------------------------------------------------------------------
// drme_pkg
// shared types and constants of the diagonal ring matrix engine
// ----------------------------------------------------------------------------
package drme_pkg;

    // field widths
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned FRAC_W     = 16;
    localparam int unsigned IDX_W      = 4;
    localparam int unsigned IDX_RANGE  = 16;
    localparam int unsigned DELTA_W    = 31;
    localparam int unsigned LAMBDA_W   = 17;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 31;

    // register reset values
    localparam logic [DELTA_W-1:0]  DELTA_RESET  = DELTA_W'(65536);
    localparam logic [LAMBDA_W-1:0] LAMBDA_RESET = LAMBDA_W'(65536);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DELTA  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LAMBDA = 1'b1;

    // saturation limits
    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_LOAD    = 2'd1,
        CMD_RANK    = 2'd2,
        CMD_COLSTEP = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_ADDR,
        ST_ACCESS,
        ST_MUL,
        ST_SUM,
        ST_DONE
    } state_t;

endpackage

@@ hdl/diagonal_ring_matrix_engine_core.sv @@
// ----------------------------------------------------------------------------
// sequence: rank update and column step pass address, access, multiply, sum and
//          done states; load address, access and done; an ignored element
//          address and done; clear sweeps the store one word a cycle, then done
// flow: one transaction in flight; the next is taken after the output register loads
// reset: asynchronous, clears control, heads, first element and configuration
//        registers; store contents are undefined until a clear or loads
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// diagonal_ring_matrix_engine_core
// symmetric matrix kept diagonal by diagonal as circular buffers in one
// synchronous memory, with clear, load, rank update and column step commands
// ----------------------------------------------------------------------------
module diagonal_ring_matrix_engine_core #(
    parameter int unsigned MAT_N = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write port
    input  logic                                  cfg_write_en,
    input  logic [drme_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [drme_pkg::CFG_DATA_W-1:0]       cfg_data,
    // command channel
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [1:0]                            command,
    input  logic [drme_pkg::IDX_W-1:0]            row_index,
    input  logic [drme_pkg::IDX_W-1:0]            col_index,
    input  logic signed [drme_pkg::DATA_W-1:0]    elem_value,
    input  logic signed [drme_pkg::DATA_W-1:0]    step_scalar,
    // result channel
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [drme_pkg::DATA_W-1:0]    result_value,
    output logic                                  overflow
);

    // store geometry: diagonal d holds MAT_N-d words starting at base(d)
    localparam int unsigned STORE_DEPTH = (MAT_N * (MAT_N + 1)) / 2;
    localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
    // only diagonals reachable by a 4-bit index carry a head
    localparam int unsigned HEAD_N  = (MAT_N < drme_pkg::IDX_RANGE) ? MAT_N
                                                                    : drme_pkg::IDX_RANGE;
    localparam int unsigned HIDX_W  = $clog2(HEAD_N);
    localparam int unsigned HEAD_W  = $clog2(MAT_N);
    localparam int unsigned CNT_W   = $clog2(MAT_N + 1);
    localparam int unsigned CMP_W   = (CNT_W > drme_pkg::IDX_W) ? CNT_W : drme_pkg::IDX_W;
    localparam int unsigned POS_W   = ((HEAD_W > drme_pkg::IDX_W) ? HEAD_W
                                                                  : drme_pkg::IDX_W) + 1;
    localparam int unsigned TRI_W   = 2 * drme_pkg::IDX_W;
    localparam int unsigned ACC_W   = 2 * drme_pkg::DATA_W;
    localparam int unsigned DATA_W  = drme_pkg::DATA_W;
    localparam int unsigned FRAC_W  = drme_pkg::FRAC_W;

    // ------------------------------------------------------------------
    // state and registers
    // ------------------------------------------------------------------
    drme_pkg::state_t state_reg, state_next;

    // configuration registers
    logic [drme_pkg::DELTA_W-1:0]  delta_reg;
    logic [drme_pkg::LAMBDA_W-1:0] lambda_reg;

    // head offsets, one per reachable diagonal
    logic [HEAD_W-1:0] head_reg [HEAD_N];
    logic signed [DATA_W-1:0] first_reg;

    // captured transaction
    drme_pkg::cmd_t              cmd_reg;
    logic [drme_pkg::IDX_W-1:0]  row_reg;
    logic [drme_pkg::IDX_W-1:0]  col_reg;
    logic signed [DATA_W-1:0]    value_reg;
    logic signed [DATA_W-1:0]    scalar_reg;

    // address stage results
    logic              ok_reg;
    logic [ADDR_W-1:0] raddr_reg;
    logic [ADDR_W-1:0] waddr_reg;

    // clear sweep counter
    logic [ADDR_W-1:0] sweep_reg;

    // diagonal store and its registered read data
    logic signed [DATA_W-1:0] store_mem [STORE_DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;

    // products and result
    logic signed [ACC_W-1:0]  prod1_reg;
    logic signed [ACC_W-1:0]  prod2_reg;
    logic signed [DATA_W-1:0] res_reg;
    logic                     ovf_reg;

    // output register
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] out_value_reg;
    logic                     out_ovf_reg;

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    logic in_fire;
    logic out_load;

    assign in_ready     = (state_reg == drme_pkg::ST_IDLE);
    assign in_fire      = in_valid && in_ready;
    assign out_load     = (state_reg == drme_pkg::ST_DONE) && (!out_valid_reg || out_ready);
    assign out_valid    = out_valid_reg;
    assign result_value = out_value_reg;
    assign overflow     = out_ovf_reg;

    // ------------------------------------------------------------------
    // address calculation (works on the captured transaction)
    // ------------------------------------------------------------------
    logic                       row_ok;
    logic                       col_ok;
    logic                       item_ok;
    logic [drme_pkg::IDX_W-1:0] diag_diff;
    logic [drme_pkg::IDX_W-1:0] diag_min;
    logic [drme_pkg::IDX_W-1:0] d_val;
    logic [HEAD_W-1:0]          head_cur;
    logic [HEAD_W-1:0]          head_new;
    logic [POS_W-1:0]           diag_len;
    logic [POS_W-1:0]           pos_sum;
    logic [POS_W-1:0]           pos_wrap;
    logic [TRI_W-1:0]           d_tri;
    logic [ADDR_W:0]            diag_base;
    logic [ADDR_W-1:0]          raddr_calc;
    logic [ADDR_W-1:0]          waddr_calc;

    always_comb
    begin
        row_ok  = CMP_W'(row_reg) < CMP_W'(MAT_N);
        col_ok  = CMP_W'(col_reg) < CMP_W'(MAT_N);
        item_ok = row_ok && ((cmd_reg == drme_pkg::CMD_RANK) || col_ok);

        // diagonal number and position along it
        if (row_reg >= col_reg)
        begin
            diag_diff = row_reg - col_reg;
            diag_min  = col_reg;
        end
        else
        begin
            diag_diff = col_reg - row_reg;
            diag_min  = row_reg;
        end
        d_val = (cmd_reg == drme_pkg::CMD_RANK) ? row_reg : diag_diff;

        head_cur = head_reg[d_val[HIDX_W-1:0]];
        diag_len = POS_W'(MAT_N) - POS_W'(d_val);

        // ring position with a single wrap
        pos_sum = POS_W'(head_cur);
        if (cmd_reg != drme_pkg::CMD_RANK)
        begin
            pos_sum = POS_W'(head_cur) + POS_W'(diag_min);
        end
        pos_wrap = (pos_sum >= diag_len) ? (pos_sum - diag_len) : pos_sum;

        // head moves back by one with wrap
        head_new = (head_cur == '0) ? HEAD_W'(diag_len - POS_W'(1)) : (head_cur - 1'b1);

        // base(d) = d*MAT_N - d*(d-1)/2
        d_tri = TRI_W'((TRI_W'(d_val) * (TRI_W'(d_val) - TRI_W'(1))) >> 1);
        diag_base = (ADDR_W+1)'((ADDR_W+1)'(d_val) * (ADDR_W+1)'(MAT_N))
                  - (ADDR_W+1)'(d_tri);

        raddr_calc = ADDR_W'(diag_base + (ADDR_W+1)'(pos_wrap));
        waddr_calc = ADDR_W'(diag_base + (ADDR_W+1)'(head_new));
    end

    // ------------------------------------------------------------------
    // multiply and round
    // ------------------------------------------------------------------
    logic signed [DATA_W:0]   mul_a;
    logic signed [ACC_W:0]    prod1;
    logic signed [ACC_W-1:0]  prod2;
    logic signed [ACC_W-1:0]  value_shift;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  acc_round;
    logic signed [ACC_W-1:0]  quot;
    logic signed [DATA_W-1:0] res_calc;
    logic                     ovf_calc;

    always_comb
    begin
        // lambda*old for rank update, scalar*entry for column step
        if (cmd_reg == drme_pkg::CMD_RANK)
        begin
            mul_a = $signed((DATA_W+1)'(lambda_reg));
        end
        else
        begin
            mul_a = $signed({scalar_reg[DATA_W-1], scalar_reg});
        end
        prod1 = mul_a * rd_data_reg;
        prod2 = first_reg * value_reg;

        value_shift = $signed({{(ACC_W-DATA_W-FRAC_W){value_reg[DATA_W-1]}},
                               value_reg, FRAC_W'(0)});

        if (cmd_reg == drme_pkg::CMD_RANK)
        begin
            acc = prod1_reg + prod2_reg;
        end
        else
        begin
            acc = value_shift - prod1_reg;
        end

        // round half up, then floor shift
        acc_round = acc + $signed(ACC_W'(1) << (FRAC_W - 1));
        quot      = acc_round >>> FRAC_W;

        ovf_calc = 1'b0;
        res_calc = quot[DATA_W-1:0];
        if (!quot[ACC_W-1] && (quot[ACC_W-2:DATA_W-1] != '0))
        begin
            ovf_calc = 1'b1;
            res_calc = drme_pkg::SAT_MAX;
        end
        else if (quot[ACC_W-1] && !(&quot[ACC_W-2:DATA_W-1]))
        begin
            ovf_calc = 1'b1;
            res_calc = drme_pkg::SAT_MIN;
        end
    end

    // ------------------------------------------------------------------
    // sequencer: next state and store port control
    // ------------------------------------------------------------------
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic                     mem_re;

    always_comb
    begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_waddr  = raddr_reg;
        mem_wdata  = value_reg;
        mem_re     = 1'b0;

        case (state_reg)
            drme_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (drme_pkg::cmd_t'(command) == drme_pkg::CMD_CLEAR)
                    begin
                        state_next = drme_pkg::ST_CLEAR;
                    end
                    else
                    begin
                        state_next = drme_pkg::ST_ADDR;
                    end
                end
            end
            drme_pkg::ST_CLEAR:
            begin
                // main diagonal gets delta, everything else zero
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
                mem_wdata = (sweep_reg < ADDR_W'(MAT_N)) ? $signed(DATA_W'(delta_reg)) : '0;
                if (sweep_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    state_next = drme_pkg::ST_DONE;
                end
            end
            drme_pkg::ST_ADDR:
            begin
                state_next = item_ok ? drme_pkg::ST_ACCESS : drme_pkg::ST_DONE;
            end
            drme_pkg::ST_ACCESS:
            begin
                if (cmd_reg == drme_pkg::CMD_LOAD)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = raddr_reg;
                    mem_wdata  = value_reg;
                    state_next = drme_pkg::ST_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = drme_pkg::ST_MUL;
                end
            end
            drme_pkg::ST_MUL:
            begin
                state_next = drme_pkg::ST_SUM;
            end
            drme_pkg::ST_SUM:
            begin
                state_next = drme_pkg::ST_DONE;
            end
            drme_pkg::ST_DONE:
            begin
                // new head value goes back to the store; repeating it while
                // the output is stalled rewrites the same word
                if ((cmd_reg == drme_pkg::CMD_RANK) && ok_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = waddr_reg;
                    mem_wdata = res_reg;
                end
                if (out_load)
                begin
                    state_next = drme_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = drme_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= drme_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delta_reg  <= drme_pkg::DELTA_RESET;
            lambda_reg <= drme_pkg::LAMBDA_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                drme_pkg::REG_DELTA:  delta_reg  <= cfg_data[drme_pkg::DELTA_W-1:0];
                drme_pkg::REG_LAMBDA: lambda_reg <= cfg_data[drme_pkg::LAMBDA_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // heads, first element, sweep counter, ok flag, output valid
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HEAD_N; i++)
            begin
                head_reg[i] <= '0;
            end
            first_reg     <= '0;
            sweep_reg     <= '0;
            ok_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // clear resets every head at once while the store is swept
            if (in_fire && (drme_pkg::cmd_t'(command) == drme_pkg::CMD_CLEAR))
            begin
                for (int i = 0; i < HEAD_N; i++)
                begin
                    head_reg[i] <= '0;
                end
                sweep_reg <= '0;
                ok_reg    <= 1'b0;
            end

            if (state_reg == drme_pkg::ST_CLEAR)
            begin
                sweep_reg <= sweep_reg + 1'b1;
            end

            if (state_reg == drme_pkg::ST_ADDR)
            begin
                ok_reg <= item_ok;
                if (item_ok && (cmd_reg == drme_pkg::CMD_RANK))
                begin
                    head_reg[d_val[HIDX_W-1:0]] <= head_new;
                    if (row_reg == '0)
                    begin
                        first_reg <= value_reg;
                    end
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg    <= drme_pkg::cmd_t'(command);
            row_reg    <= row_index;
            col_reg    <= col_index;
            value_reg  <= elem_value;
            scalar_reg <= step_scalar;
            // clear, load and ignored commands answer zero
            res_reg    <= '0;
            ovf_reg    <= 1'b0;
        end

        if (state_reg == drme_pkg::ST_ADDR)
        begin
            raddr_reg <= raddr_calc;
            waddr_reg <= waddr_calc;
        end

        if (state_reg == drme_pkg::ST_MUL)
        begin
            prod1_reg <= prod1[ACC_W-1:0];
            prod2_reg <= prod2;
        end

        if (state_reg == drme_pkg::ST_SUM)
        begin
            res_reg <= res_calc;
            ovf_reg <= ovf_calc;
        end

        if (out_load)
        begin
            out_value_reg <= res_reg;
            out_ovf_reg   <= ovf_reg;
        end
    end

    // ------------------------------------------------------------------
    // diagonal store: one write port, one registered read port
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= store_mem[raddr_reg];
        end
    end

endmodule

@@ hdl/drme_checker.sv @@
// ----------------------------------------------------------------------------
// drme_checker
// port-level checks of the diagonal ring matrix engine, bound to the top level
// ----------------------------------------------------------------------------
module drme_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic [1:0]                         command,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [drme_pkg::DATA_W-1:0] result_value,
    input logic                               overflow
);

    // a stalled result transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(overflow))
    else $error("result transaction changed while stalled");

    // saturated results sit on a range limit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |->
            (result_value == drme_pkg::SAT_MAX) || (result_value == drme_pkg::SAT_MIN))
    else $error("overflow flagged on an unsaturated value");

    // one transaction in flight: busy right after acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("command taken while previous one still in work");

    // clear keeps the engine busy while it sweeps the store
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (command == drme_pkg::CMD_CLEAR) |=> !in_ready ##1 !in_ready)
    else $error("clear finished too early");

endmodule

bind diagonal_ring_matrix_engine_core drme_checker u_drme_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .overflow     (overflow)
);
